### hw/rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types, constants and round functions for the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned HASH_WORDS    = 5;
    localparam int unsigned BLOCK_W       = 512;
    localparam int unsigned ROUNDS        = 80;
    localparam int unsigned QUEUE_DEPTH_D = 4;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_hash [HASH_WORDS];

    // Chaining state after reset and after every digest
    localparam t_word IV0 = 32'h6745_2301;
    localparam t_word IV1 = 32'hEFCD_AB89;
    localparam t_word IV2 = 32'h98BA_DCFE;
    localparam t_word IV3 = 32'h1032_5476;
    localparam t_word IV4 = 32'hC3D2_E1F0;

    localparam t_word K0 = 32'h5A82_7999;
    localparam t_word K1 = 32'h6ED9_EBA1;
    localparam t_word K2 = 32'h8F1B_BCDC;
    localparam t_word K3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;

    // Byte position in a block where the length field begins
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd4;

    // Command held in the queue between front and back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_cmd;

    // Back part to compression engine
    typedef struct packed {
        logic start;
        logic reinit;
    } t_eng_ctl;

    function automatic t_word rotl(input t_word x, input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic t_word round_k(input logic [6:0] rnd);
        case (rnd) inside
            [7'd0:7'd19]:  round_k = K0;
            [7'd20:7'd39]: round_k = K1;
            [7'd40:7'd59]: round_k = K2;
            default:       round_k = K3;
        endcase
    endfunction

    function automatic t_word round_f(input logic [6:0] rnd, input t_word b,
                                      input t_word c, input t_word d);
        case (rnd) inside
            [7'd0:7'd19]:  round_f = (b & c) | (~b & d);
            [7'd40:7'd59]: round_f = (b & c) | (b & d) | (c & d);
            default:       round_f = b ^ c ^ d;
        endcase
    endfunction

endpackage

### hw/rtl/sha1md_if.sv
// ----------------------------------------------------------------------------
// sha1md_if
// Valid/ready channels for message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha1md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface sha1md_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

### hw/rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 digest of a byte stream, one byte per input transfer.
// ----------------------------------------------------------------------------
// Input channel i_in carries data_byte, byte_present and end_of_message.
// A transfer with end_of_message closes the message; byte_present=0 on it
// closes without adding a byte (an empty message gives the empty digest).
// Transfers with neither flag are taken and dropped.
// Output channel o_out returns five digest words, word 0 first, the fifth
// with last_word set, from a registered output stage.
// Throughput: a byte per cycle while collecting; each 64-byte block holds
// the single round engine through its 80 rounds plus the fold into the
// chaining state, and the byte that completes the next block waits for the
// engine to go idle.
// After the closing transfer the padding bytes are shifted in and one or
// two compressions run before the first digest word is returned.
// A stalled receiver holds the digest words; the command queue keeps
// taking input until it fills, then ready drops.
// Reset restores the initial chaining state and clears length and fill.
// ----------------------------------------------------------------------------
module sha1_message_digest #(
    parameter int unsigned QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sha1md_in_if.sink     i_in,
    sha1md_out_if.source  o_out
);
    import sha1md_pkg::*;

    logic                cmd_valid, cmd_ready, busy;
    t_cmd                cmd;
    t_eng_ctl            ctl;
    logic [BLOCK_W-1:0]  block;
    t_hash               hash;

    sha1md_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    sha1md_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_ctl       (ctl),
        .o_block     (block),
        .i_busy      (busy),
        .i_hash      (hash),
        .o_out       (o_out)
    );

    sha1md_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_block (block),
        .o_busy  (busy),
        .o_hash  (hash)
    );

endmodule

### hw/rtl/sha1md_front.sv
// ----------------------------------------------------------------------------
// sha1md_front
// Input side: takes item transfers, drops empty non-closing items and
// queues the rest as commands for the back part.
// ----------------------------------------------------------------------------
module sha1md_front #(
    parameter int unsigned QUEUE_DEPTH = sha1md_pkg::QUEUE_DEPTH_D
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sha1md_in_if.sink           i_in,
    output logic                o_cmd_valid,
    output sha1md_pkg::t_cmd    o_cmd,
    input  logic                i_cmd_ready
);
    import sha1md_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          push, pop, in_xfer;
    t_cmd          in_cmd;

    // Classify the incoming item
    assign in_cmd.data_byte      = i_in.data_byte;
    assign in_cmd.byte_present   = i_in.byte_present;
    assign in_cmd.end_of_message = i_in.end_of_message;

    assign i_in.ready  = (r_count != CW'(QUEUE_DEPTH));
    assign in_xfer     = i_in.valid && i_in.ready;
    assign push        = in_xfer && (i_in.byte_present || i_in.end_of_message);

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign pop         = o_cmd_valid && i_cmd_ready;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

### hw/rtl/sha1md_round.sv
// ----------------------------------------------------------------------------
// sha1md_round
// Compression engine: one SHA-1 round per cycle over a 16-word schedule
// window, then a final step that folds the result into the chaining state.
// ----------------------------------------------------------------------------
module sha1md_round (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sha1md_pkg::t_eng_ctl          i_ctl,
    input  logic [sha1md_pkg::BLOCK_W-1:0] i_block,
    output logic                          o_busy,
    output sha1md_pkg::t_hash             o_hash
);
    import sha1md_pkg::*;

    t_word       r_w [16];
    t_word       r_v [HASH_WORDS];
    t_word       r_h [HASH_WORDS];
    logic [6:0]  r_round;
    logic        r_busy;
    logic        finishing;
    t_word       w_new, t_sum;

    assign finishing = r_busy && (r_round == 7'(ROUNDS));
    assign o_busy    = r_busy;
    assign o_hash    = r_h;

    // Next schedule word and round sum
    assign w_new = rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 1);
    assign t_sum = rotl(r_v[0], 5) + round_f(r_round, r_v[1], r_v[2], r_v[3])
                 + r_v[4] + round_k(r_round) + r_w[0];

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
        end else if (i_ctl.start) begin
            r_busy  <= 1'b1;
            r_round <= '0;
        end else if (finishing) begin
            r_busy  <= 1'b0;
        end else if (r_busy) begin
            r_round <= r_round + 1'b1;
        end
    end

    // Schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            for (int k = 0; k < 16; k++) begin
                r_w[k] <= i_block[BLOCK_W - 1 - 32 * k -: 32];
            end
            for (int k = 0; k < HASH_WORDS; k++) begin
                r_v[k] <= r_h[k];
            end
        end else if (r_busy && !finishing) begin
            for (int k = 0; k < 15; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[15] <= w_new;
            r_v[4]  <= r_v[3];
            r_v[3]  <= r_v[2];
            r_v[2]  <= rotl(r_v[1], 30);
            r_v[1]  <= r_v[0];
            r_v[0]  <= t_sum;
        end
    end

    // Chaining state: fold in after the last round, restore for a new message
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.reinit) begin
            r_h[0] <= IV0;
            r_h[1] <= IV1;
            r_h[2] <= IV2;
            r_h[3] <= IV3;
            r_h[4] <= IV4;
        end else if (finishing) begin
            for (int k = 0; k < HASH_WORDS; k++) begin
                r_h[k] <= r_h[k] + r_v[k];
            end
        end
    end

endmodule

### hw/rtl/sha1md_back.sv
// ----------------------------------------------------------------------------
// sha1md_back
// Back part: packs bytes into the block buffer, runs the padding sequence,
// launches compressions and streams the digest through an output register.
// ----------------------------------------------------------------------------
module sha1md_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    input  sha1md_pkg::t_cmd               i_cmd,
    output logic                           o_cmd_ready,
    output sha1md_pkg::t_eng_ctl           o_ctl,
    output logic [sha1md_pkg::BLOCK_W-1:0] o_block,
    input  logic                           i_busy,
    input  sha1md_pkg::t_hash              i_hash,
    sha1md_out_if.source                   o_out
);
    import sha1md_pkg::*;

    typedef enum logic [5:0] {
        S_COLLECT  = 6'b000001,
        S_PAD_MARK = 6'b000010,
        S_PAD_ZERO = 6'b000100,
        S_PAD_LEN  = 6'b001000,
        S_WAIT     = 6'b010000,
        S_OUT      = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [BLOCK_W-1:0]   r_buf;
    logic [5:0]           r_fill;
    logic [60:0]          r_len;     // message length in bytes
    logic [2:0]           r_sel;
    logic                 r_out_valid;
    t_word                r_out_word;
    logic [2:0]           r_out_idx;
    logic                 r_out_last;

    logic                 can_shift, shift_en, count_en, load_out, out_xfer;
    logic [7:0]           shift_byte;
    logic [63:0]          len_bits;
    logic [2:0]           len_sel;
    t_word                sel_word;

    assign can_shift = (r_fill != LAST_POS) || !i_busy;
    assign len_bits  = {r_len, 3'b000};
    assign len_sel   = 3'd7 - r_fill[2:0];
    assign o_block   = {r_buf[BLOCK_W-9:0], shift_byte};
    assign out_xfer  = r_out_valid && o_out.ready;

    // Pick the chaining word for the next digest transfer
    always_comb begin
        case (r_sel)
            3'd0:    sel_word = i_hash[0];
            3'd1:    sel_word = i_hash[1];
            3'd2:    sel_word = i_hash[2];
            3'd3:    sel_word = i_hash[3];
            3'd4:    sel_word = i_hash[4];
            default: sel_word = i_hash[4];
        endcase
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        o_cmd_ready  = 1'b0;
        shift_en     = 1'b0;
        count_en     = 1'b0;
        shift_byte   = i_cmd.data_byte;
        load_out     = 1'b0;
        o_ctl.reinit = 1'b0;
        case (r_state)
            S_COLLECT: begin
                if (i_cmd_valid) begin
                    if (!i_cmd.byte_present) begin
                        o_cmd_ready = 1'b1;
                        if (i_cmd.end_of_message) n_state = S_PAD_MARK;
                    end else if (can_shift) begin
                        o_cmd_ready = 1'b1;
                        shift_en    = 1'b1;
                        count_en    = 1'b1;
                        if (i_cmd.end_of_message) n_state = S_PAD_MARK;
                    end
                end
            end
            S_PAD_MARK: begin
                shift_byte = PAD_MARK_BYTE;
                if (can_shift) begin
                    shift_en = 1'b1;
                    n_state  = S_PAD_ZERO;
                end
            end
            S_PAD_ZERO: begin
                shift_byte = PAD_ZERO_BYTE;
                if (r_fill == LEN_POS) begin
                    n_state = S_PAD_LEN;
                end else if (can_shift) begin
                    shift_en = 1'b1;
                end
            end
            S_PAD_LEN: begin
                shift_byte = len_bits[{len_sel, 3'b000} +: 8];
                if (can_shift) begin
                    shift_en = 1'b1;
                    if (r_fill == LAST_POS) n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!i_busy) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    if (r_sel == LAST_IDX) begin
                        o_ctl.reinit = 1'b1;
                        n_state      = S_COLLECT;
                    end
                end
            end
            default: n_state = S_COLLECT;
        endcase
        // Launch a compression whenever a byte completes the block
        o_ctl.start = shift_en && (r_fill == LAST_POS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_fill      <= '0;
            r_len       <= '0;
            r_sel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (shift_en) r_fill <= r_fill + 1'b1;
            if (o_ctl.reinit) begin
                r_len <= '0;
            end else if (count_en) begin
                r_len <= r_len + 1'b1;
            end
            if (load_out) begin
                r_sel <= (r_sel == LAST_IDX) ? 3'd0 : r_sel + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Block buffer and output payload
    always_ff @(posedge i_clk) begin
        if (shift_en) r_buf <= o_block;
        if (load_out) begin
            r_out_word <= sel_word;
            r_out_idx  <= r_sel;
            r_out_last <= (r_sel == LAST_IDX);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_word = r_out_word;
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = r_out_last;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.start |-> !i_busy)
        else $error("compression launched while engine busy");

    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAD_LEN) |-> (r_fill[5:3] == 3'b111))
        else $error("length field outside last eight bytes of block");

    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (!i_busy && r_fill == '0))
        else $error("digest read while engine busy or block partly filled");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_idx == LAST_IDX)))
        else $error("last flag does not match digest word index");

endmodule
